FILE: hw/rtl/positional_list_insert_delete_assert.svh
// Assertion macros for the positional list block.
`ifndef POSITIONAL_LIST_INSERT_DELETE_ASSERT_SVH
`define POSITIONAL_LIST_INSERT_DELETE_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define PLI_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("positional list assertion failed");

// Check that cons holds in the cycle after ante.
`define PLI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("positional list assertion failed");

`endif

FILE: hw/rtl/pli_pkg.sv
`timescale 1ns / 1ps

package pli_pkg;

    localparam int DEPTH       = 64;
    localparam int DATA_WIDTH  = 32;
    localparam int IDX_W       = $clog2(DEPTH);
    localparam int POS_W       = 7;
    localparam int CNT_W       = 7;
    localparam int VALUE_W     = 32;
    localparam int GROUP       = 8;
    localparam int NUM_GROUPS  = (DEPTH + GROUP - 1) / GROUP;

    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_DELETE = 2'd1,
        KIND_READ   = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_FULL   = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_GATHER,
        S_OUT
    } state_t;

    typedef struct packed {
        logic             insert;
        logic             delete;
        logic             pick;
        logic [IDX_W-1:0] idx;
    } cmd_t;

endpackage

FILE: hw/rtl/pli_cell.sv
`timescale 1ns / 1ps

module pli_cell (
    input  logic                           clk,
    input  pli_pkg::cmd_t                  cmd,
    input  logic [pli_pkg::IDX_W-1:0]      my_idx,
    input  logic [pli_pkg::DATA_WIDTH-1:0] value,
    input  logic [pli_pkg::DATA_WIDTH-1:0] prev_data,
    input  logic [pli_pkg::DATA_WIDTH-1:0] next_data,
    output logic [pli_pkg::DATA_WIDTH-1:0] data,
    output logic [pli_pkg::DATA_WIDTH-1:0] sel_data
);

    logic [pli_pkg::DATA_WIDTH-1:0] data_reg;
    logic [pli_pkg::DATA_WIDTH-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        if (cmd.insert)
        begin
            if (my_idx > cmd.idx)
            begin
                data_next = prev_data;
            end
            else if (my_idx == cmd.idx)
            begin
                data_next = value;
            end
        end
        else if (cmd.delete)
        begin
            if (my_idx >= cmd.idx)
            begin
                data_next = next_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data     = data_reg;
    assign sel_data = (cmd.pick && (my_idx == cmd.idx)) ? data_reg : '0;

endmodule

FILE: hw/rtl/pli_gather.sv
`timescale 1ns / 1ps

module pli_gather (
    input  logic                           clk,
    input  logic                           grp_en,
    input  logic                           elem_en,
    input  logic [pli_pkg::DATA_WIDTH-1:0] sel_data [pli_pkg::DEPTH],
    output logic [pli_pkg::DATA_WIDTH-1:0] element
);

    logic [pli_pkg::DATA_WIDTH-1:0] grp_reg  [pli_pkg::NUM_GROUPS];
    logic [pli_pkg::DATA_WIDTH-1:0] grp_next [pli_pkg::NUM_GROUPS];
    logic [pli_pkg::DATA_WIDTH-1:0] elem_reg;
    logic [pli_pkg::DATA_WIDTH-1:0] elem_next;

    always_comb
    begin
        for (int g = 0; g < pli_pkg::NUM_GROUPS; g++)
        begin
            grp_next[g] = '0;
            for (int k = 0; k < pli_pkg::GROUP; k++)
            begin
                if (g * pli_pkg::GROUP + k < pli_pkg::DEPTH)
                begin
                    grp_next[g] = grp_next[g] | sel_data[g * pli_pkg::GROUP + k];
                end
            end
        end
    end

    always_comb
    begin
        elem_next = '0;
        for (int g = 0; g < pli_pkg::NUM_GROUPS; g++)
        begin
            elem_next = elem_next | grp_reg[g];
        end
    end

    always_ff @(posedge clk)
    begin
        if (grp_en)
        begin
            grp_reg <= grp_next;
        end
        if (elem_en)
        begin
            elem_reg <= elem_next;
        end
    end

    assign element = elem_reg;

endmodule

FILE: hw/rtl/positional_list_insert_delete.sv
// An accepted input beat passes through the gather state, then the output state.
// One beat at a time: the output stage holds until taken,
// and the input reopens the cycle after the result beat leaves.
// The result passes the two-level registered OR tree that picks the entry from the row.
// Reset: count clears to zero and control goes idle; entries are undefined until written.
`timescale 1ns / 1ps
`include "positional_list_insert_delete_assert.svh"

module positional_list_insert_delete (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  kind,
    input  logic [pli_pkg::POS_W-1:0]   position,
    input  logic [pli_pkg::VALUE_W-1:0] value,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [1:0]                  status,
    output logic [pli_pkg::CNT_W-1:0]   count,
    output logic [pli_pkg::VALUE_W-1:0] element
);

    pli_pkg::state_t state_reg;
    pli_pkg::state_t state_next;
    logic [pli_pkg::CNT_W-1:0] count_reg;
    logic [pli_pkg::CNT_W-1:0] count_next;
    pli_pkg::status_t status_reg;
    pli_pkg::status_t status_next;

    logic in_acc;
    logic pos_nonzero;
    logic ins_pos_ok;
    logic rd_pos_ok;
    logic is_full;
    pli_pkg::cmd_t cmd;

    logic [pli_pkg::DATA_WIDTH-1:0] data_arr [pli_pkg::DEPTH];
    logic [pli_pkg::DATA_WIDTH-1:0] sel_arr  [pli_pkg::DEPTH];
    logic [pli_pkg::DATA_WIDTH-1:0] value_d;
    logic [pli_pkg::DATA_WIDTH-1:0] picked;

    assign in_ready = (state_reg == pli_pkg::S_IDLE);
    assign in_acc   = in_valid && in_ready;

    assign pos_nonzero = (position != '0);
    assign ins_pos_ok  = pos_nonzero
                         && ({1'b0, position} <= ({1'b0, count_reg} + (pli_pkg::CNT_W+1)'(1)));
    assign rd_pos_ok   = pos_nonzero && (position <= count_reg);
    assign is_full     = (count_reg >= pli_pkg::CNT_W'(pli_pkg::DEPTH));
    assign value_d     = pli_pkg::DATA_WIDTH'(value);

    always_comb
    begin
        cmd         = '0;
        cmd.idx     = pli_pkg::IDX_W'(position - pli_pkg::POS_W'(1));
        status_next = pli_pkg::ST_BADPOS;
        count_next  = count_reg;
        case (kind)
            pli_pkg::KIND_INSERT:
            begin
                if (!ins_pos_ok)
                begin
                    status_next = pli_pkg::ST_BADPOS;
                end
                else if (is_full)
                begin
                    status_next = pli_pkg::ST_FULL;
                end
                else
                begin
                    status_next = pli_pkg::ST_OK;
                    cmd.insert  = in_acc;
                    count_next  = count_reg + pli_pkg::CNT_W'(1);
                end
            end
            pli_pkg::KIND_DELETE:
            begin
                if (rd_pos_ok)
                begin
                    status_next = pli_pkg::ST_OK;
                    cmd.delete  = in_acc;
                    cmd.pick    = in_acc;
                    count_next  = count_reg - pli_pkg::CNT_W'(1);
                end
            end
            pli_pkg::KIND_READ:
            begin
                if (rd_pos_ok)
                begin
                    status_next = pli_pkg::ST_OK;
                    cmd.pick    = in_acc;
                end
            end
            default:
            begin
                status_next = pli_pkg::ST_BADPOS;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pli_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = pli_pkg::S_GATHER;
                end
            end
            pli_pkg::S_GATHER:
            begin
                state_next = pli_pkg::S_OUT;
            end
            pli_pkg::S_OUT:
            begin
                if (out_ready)
                begin
                    state_next = pli_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = pli_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid = (state_reg == pli_pkg::S_OUT);
        status    = status_reg;
        count     = count_reg;
        element   = pli_pkg::VALUE_W'(picked);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pli_pkg::S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_acc)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            status_reg <= status_next;
        end
    end

    for (genvar g = 0; g < pli_pkg::DEPTH; g++)
    begin : g_cell
        logic [pli_pkg::DATA_WIDTH-1:0] prev_d;
        logic [pli_pkg::DATA_WIDTH-1:0] next_d;

        if (g == 0)
        begin : g_first
            assign prev_d = '0;
        end
        else
        begin : g_mid_prev
            assign prev_d = data_arr[g-1];
        end

        if (g == pli_pkg::DEPTH - 1)
        begin : g_last
            assign next_d = '0;
        end
        else
        begin : g_mid_next
            assign next_d = data_arr[g+1];
        end

        pli_cell u_cell (
            .clk       (clk),
            .cmd       (cmd),
            .my_idx    (pli_pkg::IDX_W'(g)),
            .value     (value_d),
            .prev_data (prev_d),
            .next_data (next_d),
            .data      (data_arr[g]),
            .sel_data  (sel_arr[g])
        );
    end

    pli_gather u_gather (
        .clk      (clk),
        .grp_en   (in_acc),
        .elem_en  (state_reg == pli_pkg::S_GATHER),
        .sel_data (sel_arr),
        .element  (picked)
    );

    `PLI_ASSERT_SAME(a_count_bound, clk, rst_n, 1'b1, count_reg <= pli_pkg::CNT_W'(pli_pkg::DEPTH))
    `PLI_ASSERT_NEXT(a_accept_gather, clk, rst_n, in_acc, state_reg == pli_pkg::S_GATHER)
    `PLI_ASSERT_SAME(a_err_zero, clk, rst_n, out_valid && (status != pli_pkg::ST_OK), element == '0)
    `PLI_ASSERT_NEXT(a_count_hold, clk, rst_n, !in_acc, $stable(count_reg))

endmodule
